// ----- hdl/svf_pkg.sv -----
// shared types, constants and helper functions for the seven segment value formatter
package svf_pkg;

	typedef enum logic [1:0] {
		KIND_FREQ  = 2'd0,
		KIND_VOL   = 2'd1,
		KIND_DELAY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] num;
	} entry_t;

	localparam int SVF_QUEUE_DEPTH = 2;
	localparam int SVF_DIGITS      = 4;

	localparam logic [7:0] SEG_BLANK = 8'hFF;
	localparam logic [7:0] SEG_V     = 8'hC1;
	localparam logic [7:0] SEG_D     = 8'hA1;
	localparam logic [7:0] SEG_ALL   = 8'h00;

	localparam logic [7:0] DIGIT_PATTERN [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	// reciprocal multiply, exact for every 16-bit value
	function automatic logic [15:0] div10(input logic [15:0] x);
		logic [34:0] prod;
		prod = 35'(x) * 35'd52429;
		return prod[34:19];
	endfunction

	function automatic logic [7:0] seg_of(input logic [15:0] d);
		logic [7:0] pat;
		if (d > 16'd9) begin
			pat = SEG_ALL;
		end else begin
			pat = DIGIT_PATTERN[d[3:0]];
		end
		return pat;
	endfunction

endpackage

// ----- hdl/seven_segment_value_formatter_unit.sv -----
// top level of the seven segment value formatter
// a request accepted into an empty block is queued, then shown via the result register
// throughput: four results per request, one per cycle while each is popped when shown
// the back part sets the rate, taking apart one decimal digit each cycle unless stalled
// the front queue holds QUEUE_DEPTH requests, so requests are taken while results wait
// reset: arst_n empties the queue and the result stage at once; no clearing pass
module seven_segment_value_formatter_unit #(
	parameter int QUEUE_DEPTH = svf_pkg::SVF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [15:0] value,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  digit_enable,
	output logic [7:0]  segments,
	output logic        last
);
	import svf_pkg::*;

	entry_t front_entry;
	entry_t q_data;
	logic   q_empty;
	logic   q_rd;

	svf_front u_front (
		.kind  (kind),
		.value (value),
		.entry (front_entry)
	);

	svf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_data (front_entry),
		.full    (full),
		.rd      (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	svf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.digit_enable (digit_enable),
		.segments     (segments),
		.last         (last)
	);

endmodule

// ----- hdl/svf_front.sv -----
// front part: classifies a request and prepares the number to take apart
module svf_front (
	input  logic [1:0]      kind,
	input  logic [15:0]     value,
	output svf_pkg::entry_t entry
);
	import svf_pkg::*;

	kind_t k;

	always_comb begin
		k = kind_t'(kind);
		entry.kind = k;
		case (k)
			KIND_FREQ: begin
				entry.num = div10(value);
			end
			KIND_VOL: begin
				entry.num = value;
			end
			KIND_DELAY: begin
				entry.num = {8'd0, value[7:0]};
			end
			default: begin
				entry.num = '0;
			end
		endcase
	end

endmodule

// ----- hdl/svf_queue.sv -----
// short queue between the front and the back part
module svf_queue #(
	parameter int DEPTH = svf_pkg::SVF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  svf_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd,
	output svf_pkg::entry_t rd_data,
	output logic            empty
);
	import svf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

endmodule

// ----- hdl/svf_back.sv -----
// back part: peels one decimal digit a cycle unless held; drives result reg
module svf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  svf_pkg::entry_t q_data,
	output logic            q_rd,
	input  logic            pop,
	output logic            empty,
	output logic [3:0]      digit_enable,
	output logic [7:0]      segments,
	output logic            last
);
	import svf_pkg::*;

	localparam logic [1:0] LAST_K = 2'(SVF_DIGITS - 1);

	logic [1:0]  k_q;
	logic [15:0] n_q;
	logic        out_v_q;
	logic [3:0]  de_q;
	logic [7:0]  seg_q;
	logic        last_q;

	logic        advance;
	logic [15:0] cur_n;
	logic [15:0] quo;
	logic [15:0] rem;
	logic [15:0] digit;
	logic [7:0]  seg;

	assign advance = !q_empty && (!out_v_q || pop);
	assign q_rd    = advance && (k_q == LAST_K);
	assign cur_n   = (k_q == 2'd0) ? q_data.num : n_q;
	assign quo     = div10(cur_n);
	assign rem     = cur_n - ((quo << 3) + (quo << 1));

	always_comb begin
		digit = rem;
		if (k_q == LAST_K || (q_data.kind == KIND_VOL && k_q == 2'd1)) begin
			digit = cur_n;
		end
		seg = seg_of(digit);
		case (q_data.kind)
			KIND_FREQ: begin
				if (k_q == LAST_K && cur_n == '0) begin
					seg = SEG_BLANK;
				end
			end
			KIND_VOL: begin
				if (k_q == 2'd2) begin
					seg = SEG_BLANK;
				end else if (k_q == LAST_K) begin
					seg = SEG_V;
				end
			end
			KIND_DELAY: begin
				if (k_q == LAST_K) begin
					seg = SEG_D;
				end
			end
			default: begin
				seg = SEG_BLANK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (advance) begin
				k_q     <= 2'(k_q + 2'd1);
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			n_q    <= quo;
			de_q   <= ~(4'b0001 << k_q);
			seg_q  <= seg;
			last_q <= (k_q == LAST_K);
		end
	end

	assign empty        = !out_v_q;
	assign digit_enable = de_q;
	assign segments     = seg_q;
	assign last         = last_q;

endmodule

// ----- hdl/svf_checker.sv -----
// port level checks for the seven segment value formatter, bound to the top level
module svf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic [3:0] digit_enable,
	input logic [7:0] segments,
	input logic       last
);

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digit_enable) && $stable(segments)
			&& $stable(last)))
		else $error("result changed while waiting");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> $onehot(~digit_enable))
		else $error("digit enable not one-hot low");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (digit_enable == 4'b0111)))
		else $error("last flag not on leftmost digit");

	// digits of one request follow each other without a gap
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=>
			(!empty && digit_enable == {$past(digit_enable[2:0]), 1'b1}))
		else $error("digit sequence broken");

endmodule

bind seven_segment_value_formatter_unit svf_checker u_svf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pop          (pop),
	.empty        (empty),
	.digit_enable (digit_enable),
	.segments     (segments),
	.last         (last)
);

// ----- tb/sv/digit_stream_checker.sv -----
// checker that predicts the four digit results of each request and compares them on pop
module digit_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  kind,
	input  logic [15:0] value,
	input  logic        pop,
	input  logic        empty,
	input  logic [3:0]  digit_enable,
	input  logic [7:0]  segments,
	input  logic        last,
	output int          outstanding,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;
	import svf_pkg::*;

	typedef struct packed {
		logic [3:0] enable;
		logic [7:0] seg;
		logic       tail;
	} digit_t;

	localparam logic [7:0] GLYPH [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	digit_t digits_due [$];
	int     bad_digits = 0;

	function automatic logic [7:0] glyph(input int unsigned d);
		logic [7:0] g;
		if (d > 9) begin
			g = SEG_ALL;
		end else begin
			g = GLYPH[d];
		end
		return g;
	endfunction

	function automatic void format_digits(input kind_t mode, input logic [15:0] raw);
		int unsigned f;
		int unsigned b;
		logic [7:0]  seg [4];
		digit_t      d;
		f = raw / 10;
		b = {24'd0, raw[7:0]};
		case (mode)
			KIND_FREQ: begin
				seg[0] = glyph(f % 10);
				seg[1] = glyph((f / 10) % 10);
				seg[2] = glyph((f / 100) % 10);
				seg[3] = (f / 1000 == 0) ? SEG_BLANK : glyph(f / 1000);
			end
			KIND_VOL: begin
				seg[0] = glyph(raw % 10);
				seg[1] = glyph(raw / 10);
				seg[2] = SEG_BLANK;
				seg[3] = SEG_V;
			end
			KIND_DELAY: begin
				seg[0] = glyph(b % 10);
				seg[1] = glyph((b / 10) % 10);
				seg[2] = glyph(b / 100);
				seg[3] = SEG_D;
			end
			default: begin
				seg = '{default: SEG_BLANK};
			end
		endcase
		for (int k = 0; k < SVF_DIGITS; k++) begin
			d.enable = ~(4'b0001 << k);
			d.seg    = seg[k];
			d.tail   = (k == SVF_DIGITS - 1);
			digits_due.push_back(d);
		end
	endfunction

	task automatic complain(input string why, input digit_t want);
		bad_digits++;
		if (bad_digits <= 10) begin
			$display("%0t %s: expected enable %h seg %h last %b, got enable %h seg %h last %b",
				$realtime, why, want.enable, want.seg, want.tail,
				digit_enable, segments, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digit_t want;
		if (!arst_n) begin
			digits_due.delete();
		end else begin
			if (pop && !empty) begin
				if (digits_due.size() == 0) begin
					complain("digit with no request", '0);
				end else begin
					want = digits_due.pop_front();
					if (digit_enable !== want.enable || segments !== want.seg ||
							last !== want.tail) begin
						complain("digit mismatch", want);
					end
				end
			end
			if (push && !full) begin
				format_digits(kind_t'(kind), value);
			end
		end
		outstanding <= digits_due.size();
		failures    <= bad_digits;
	end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top: drives display requests, pops digit results and gives the verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import svf_pkg::*;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic        pop    = 1'b0;
	logic [1:0]  kind   = KIND_FREQ;
	logic [15:0] value  = '0;
	logic        full;
	logic        empty;
	logic [3:0]  digit_enable;
	logic [7:0]  segments;
	logic        last;
	int          outstanding;
	int          failures;
	logic        steady   = 1'b0;
	int          pop_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	seven_segment_value_formatter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.value        (value),
		.pop          (pop),
		.empty        (empty),
		.digit_enable (digit_enable),
		.segments     (segments),
		.last         (last)
	);

	digit_stream_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.value        (value),
		.pop          (pop),
		.empty        (empty),
		.digit_enable (digit_enable),
		.segments     (segments),
		.last         (last),
		.outstanding  (outstanding),
		.failures     (failures)
	);

	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop      <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else if (!steady && $urandom_range(7) == 0) begin
			pop      <= 1'b0;
			pop_hold <= $urandom_range(11);
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_request(input kind_t mode, input logic [15:0] raw);
		if (!steady && $urandom_range(3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
		push  <= 1'b1;
		kind  <= mode;
		value <= raw;
		do @(posedge clk); while (full);
	endtask

	function automatic kind_t pick_mode();
		int unsigned r;
		kind_t       m;
		r = $urandom_range(15);
		if (r < 5) begin
			m = KIND_FREQ;
		end else if (r < 10) begin
			m = KIND_VOL;
		end else if (r < 14) begin
			m = KIND_DELAY;
		end else begin
			m = KIND_NONE;
		end
		return m;
	endfunction

	function automatic logic [15:0] pick_value();
		logic [15:0] v;
		case ($urandom_range(4))
			0: v = 16'($urandom_range(99));
			1: v = 16'($urandom_range(999));
			2: v = 16'($urandom_range(9999));
			3: v = 16'($urandom_range(16'hFFFF, 10000));
			default: v = 16'($urandom());
		endcase
		return v;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// frequency: blank thousands below 10000, thousands digit up to six
		send_request(KIND_FREQ, 16'd0);
		send_request(KIND_FREQ, 16'd9);
		send_request(KIND_FREQ, 16'd10);
		send_request(KIND_FREQ, 16'd9999);
		send_request(KIND_FREQ, 16'd10000);
		send_request(KIND_FREQ, 16'd12345);
		send_request(KIND_FREQ, 16'd65530);
		send_request(KIND_FREQ, 16'hFFFF);
		// volume: tens above nine show all segments
		send_request(KIND_VOL, 16'd0);
		send_request(KIND_VOL, 16'd59);
		send_request(KIND_VOL, 16'd99);
		send_request(KIND_VOL, 16'd100);
		send_request(KIND_VOL, 16'hFFFF);
		// delay: only the low byte counts
		send_request(KIND_DELAY, 16'd0);
		send_request(KIND_DELAY, 16'd100);
		send_request(KIND_DELAY, 16'd255);
		send_request(KIND_DELAY, 16'hFF00);
		send_request(KIND_DELAY, 16'hABCD);
		// unused mode
		send_request(KIND_NONE, 16'd0);
		send_request(KIND_NONE, 16'hFFFF);

		for (int i = 0; i < 330; i++) begin
			steady <= (i >= 270) || ((i / 30) % 4 == 3);
			send_request(pick_mode(), pick_value());
		end
		push   <= 1'b0;
		steady <= 1'b1;

		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
